// ----- hdl/s0h_pkg.sv -----
// s0h_pkg: shared types, codes and constants of the sha-0 byte stream hash
`default_nettype none
package s0h_pkg;

  typedef logic [1:0]  cmd_t;
  typedef logic [7:0]  byte_t;
  typedef logic [31:0] word_t;
  typedef logic [2:0]  widx_t;

  // command codes
  localparam cmd_t CMD_ABSORB  = 2'd0;
  localparam cmd_t CMD_FINISH  = 2'd1;
  localparam cmd_t CMD_RESTART = 2'd2;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_FOLD = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam word_t IV0 = 32'h67452301;
  localparam word_t IV1 = 32'hEFCDAB89;
  localparam word_t IV2 = 32'h98BADCFE;
  localparam word_t IV3 = 32'h10325476;
  localparam word_t IV4 = 32'hC3D2E1F0;

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam byte_t PAD_BYTE = 8'h80;

  localparam logic [6:0] FILL_LAST = 7'd63;
  localparam logic [6:0] FILL_LEN  = 7'd56;
  localparam logic [6:0] FILL_FULL = 7'd64;

  localparam logic [6:0] RND_20   = 7'd20;
  localparam logic [6:0] RND_40   = 7'd40;
  localparam logic [6:0] RND_60   = 7'd60;
  localparam logic [6:0] RND_LAST = 7'd79;

  localparam widx_t WIDX_LAST = 3'd4;

endpackage
`default_nettype wire

// ----- hdl/s0h_chan_if.sv -----
// s0h_chan_if: valid/ready channel interfaces for command beats and digest beats
`default_nettype none
interface s0h_in_if;
  import s0h_pkg::*;
  logic  valid;
  logic  ready;
  cmd_t  cmd;
  byte_t data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface s0h_out_if;
  import s0h_pkg::*;
  logic  valid;
  logic  ready;
  word_t digest_word;
  widx_t word_index;
  logic  last_word;
  logic  ok;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, output ok, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, input ok, output ready);
endinterface
`default_nettype wire

// ----- hdl/sha0_byte_stream_hash.sv -----
// sha0_byte_stream_hash: streaming sha-0 engine with one shared round unit
`default_nettype none
// Streaming SHA-0 digest engine. Command beats come in on in_ch: absorb a byte,
// finish (pad and read the digest) or restart. An absorb beat is taken while
// idle; the byte that fills a 64-byte block starts the compression, which runs
// the single round unit through every round and then folds into the chaining
// words, so in_ch.ready is low after every 64th byte until the fold is done. A
// first finish writes 0x80 with the finish beat, then the rest of the padding
// one byte per cycle, with a step to start each compression, and runs two
// compressions when the length spills into a second block, else one; it then
// returns five digest beats, word 0 first, last_word on the fifth; a finish
// after that returns the same five beats again without new padding. A corrupted
// hash (a byte after finish, or a bit count wrapping past 2^64) answers a finish
// with one beat with ok low. Restart and cmd 3 return nothing.
// No command is taken while digest beats are being sent.
module sha0_byte_stream_hash (
  input  wire             clk,
  input  wire             rst_n,
  s0h_in_if.sink          in_ch,
  s0h_out_if.source       out_ch
);
  import s0h_pkg::*;

  // sequencer and hash state
  logic [2:0]  state_r, state_nxt;
  logic [6:0]  fill_r, fill_nxt;
  logic [63:0] bc_r, bc_nxt;
  logic        fin_r, fin_nxt;
  logic        cor_r, cor_nxt;
  logic        pad_r, pad_nxt;     // padding in progress
  logic        len_r, len_nxt;     // length bytes being written
  logic [6:0]  rnd_r, rnd_nxt;
  widx_t       idx_r, idx_nxt;
  word_t       chain_r [5];
  word_t       chain_nxt [5];

  // round unit working registers and message window
  word_t a_r, b_r, c_r, d_r, e_r;
  word_t w_r [16];

  logic        wr_en;
  byte_t       wr_byte;
  logic        start;
  logic        shift_en;
  logic [64:0] bc_sum;
  byte_t       len_byte;
  word_t       f_val, k_val, t_val, w_new;
  logic        acc;

  assign acc      = in_ch.valid && in_ch.ready;
  assign bc_sum   = {1'b0, bc_r} + 65'd8;
  // big-endian bit count byte for buffer position 56 + j
  assign len_byte = bc_r[{~fill_r[2:0], 3'b000} +: 8];
  assign w_new    = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];

  // round function and constant by round group
  always_comb begin
    priority if (rnd_r < RND_20) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = K0;
    end else if (rnd_r < RND_40) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K1;
    end else if (rnd_r < RND_60) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = K2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K3;
    end
  end

  assign t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + w_r[0] + k_val;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    bc_nxt    = bc_r;
    fin_nxt   = fin_r;
    cor_nxt   = cor_r;
    pad_nxt   = pad_r;
    len_nxt   = len_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    for (int i = 0; i < 5; i++) chain_nxt[i] = chain_r[i];
    wr_en     = 1'b0;
    wr_byte   = in_ch.data_byte;
    start     = 1'b0;
    shift_en  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          unique case (in_ch.cmd)
            CMD_ABSORB: begin
              if (fin_r || cor_r) begin
                // byte after finish or after a fault is dropped
                cor_nxt = 1'b1;
              end else begin
                wr_en    = 1'b1;
                fill_nxt = fill_r + 7'd1;
                bc_nxt   = bc_sum[63:0];
                if (bc_sum[64]) cor_nxt = 1'b1;
                if (fill_r == FILL_LAST) begin
                  start     = 1'b1;
                  state_nxt = ST_COMP;
                end
              end
            end
            CMD_FINISH: begin
              priority if (cor_r || fin_r) begin
                idx_nxt   = '0;
                state_nxt = ST_OUT;
              end else begin
                // first padding byte goes in with the finish beat
                wr_en     = 1'b1;
                wr_byte   = PAD_BYTE;
                fill_nxt  = fill_r + 7'd1;
                pad_nxt   = 1'b1;
                len_nxt   = 1'b0;
                state_nxt = ST_PAD;
              end
            end
            CMD_RESTART: begin
              chain_nxt[0] = IV0;
              chain_nxt[1] = IV1;
              chain_nxt[2] = IV2;
              chain_nxt[3] = IV3;
              chain_nxt[4] = IV4;
              fill_nxt     = '0;
              bc_nxt       = '0;
              fin_nxt      = 1'b0;
              cor_nxt      = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_PAD: begin
        priority if (fill_r == FILL_FULL) begin
          start     = 1'b1;
          state_nxt = ST_COMP;
        end else if (len_r || fill_r == FILL_LEN) begin
          wr_en    = 1'b1;
          wr_byte  = len_byte;
          fill_nxt = fill_r + 7'd1;
          len_nxt  = 1'b1;
        end else begin
          wr_en    = 1'b1;
          wr_byte  = '0;
          fill_nxt = fill_r + 7'd1;
        end
      end
      ST_COMP: begin
        shift_en = 1'b1;
        rnd_nxt  = rnd_r + 7'd1;
        if (rnd_r == RND_LAST) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        chain_nxt[4] = chain_r[4] + e_r;
        fill_nxt     = '0;
        priority if (pad_r && len_r) begin
          fin_nxt   = 1'b1;
          pad_nxt   = 1'b0;
          len_nxt   = 1'b0;
          idx_nxt   = '0;
          state_nxt = ST_OUT;
        end else if (pad_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          if (out_ch.last_word) state_nxt = ST_IDLE;
          else idx_nxt = idx_r + 3'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      fill_r     <= '0;
      bc_r       <= '0;
      fin_r      <= 1'b0;
      cor_r      <= 1'b0;
      pad_r      <= 1'b0;
      len_r      <= 1'b0;
      rnd_r      <= '0;
      idx_r      <= '0;
      chain_r[0] <= IV0;
      chain_r[1] <= IV1;
      chain_r[2] <= IV2;
      chain_r[3] <= IV3;
      chain_r[4] <= IV4;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      bc_r    <= bc_nxt;
      fin_r   <= fin_nxt;
      cor_r   <= cor_nxt;
      pad_r   <= pad_nxt;
      len_r   <= len_nxt;
      rnd_r   <= start ? 7'd0 : rnd_nxt;
      idx_r   <= idx_nxt;
      for (int i = 0; i < 5; i++) chain_r[i] <= chain_nxt[i];
    end
  end

  // round registers: loaded from the chaining words, one round per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (shift_en) begin
      a_r <= t_val;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  // block buffer as sixteen big-endian words; doubles as the schedule window
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
    end else if (wr_en) begin
      w_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= wr_byte;
    end
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = (state_r == ST_OUT);
  assign out_ch.digest_word = cor_r ? '0 : chain_r[idx_r];
  assign out_ch.word_index  = cor_r ? '0 : idx_r;
  assign out_ch.last_word   = cor_r || (idx_r == WIDX_LAST);
  assign out_ch.ok          = !cor_r;

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("command taken while digest beats pending");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("block fill beyond 64 bytes");

  a_idle_fill: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> fill_r < FILL_FULL)
    else $error("full block left uncompressed in idle");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_ch.cmd == CMD_RESTART |=> fill_r == 7'd0 && !cor_r && !fin_r)
    else $error("restart did not clear hash state");

endmodule
`default_nettype wire
